@@ rtl/core/dcf_pkg.sv @@
package dcf_pkg;

  localparam int unsigned POS_W = 4;

  localparam logic [7:0]       FRAME_HEADER = 8'hFF;
  localparam logic [7:0]       FRAME_LENGTH = 8'h07;
  localparam logic [15:0]      CRC_INIT     = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY     = 16'hA001;

  localparam logic [POS_W-1:0] POS_HEADER   = 4'd0;
  localparam logic [POS_W-1:0] POS_LENGTH   = 4'd1;
  localparam logic [POS_W-1:0] POS_LEFT_LO  = 4'd2;
  localparam logic [POS_W-1:0] POS_LEFT_HI  = 4'd3;
  localparam logic [POS_W-1:0] POS_RIGHT_LO = 4'd4;
  localparam logic [POS_W-1:0] POS_RIGHT_HI = 4'd5;
  localparam logic [POS_W-1:0] POS_FLAGS    = 4'd6;
  localparam logic [POS_W-1:0] POS_CRC_LO   = 4'd7;
  localparam logic [POS_W-1:0] POS_CRC_HI   = 4'd8;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

endpackage

@@ rtl/core/dcf_cmd_if.sv @@
interface dcf_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic        [7:0]  control_flags;

  modport source (
    output valid, left_speed, right_speed, control_flags,
    input  ready
  );

  modport sink (
    input  valid, left_speed, right_speed, control_flags,
    output ready
  );
endinterface

@@ rtl/core/dcf_byte_if.sv @@
interface dcf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (
    output valid, out_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, out_byte, last_byte,
    output ready
  );
endinterface

@@ rtl/core/dcf_crc_unit.sv @@
module dcf_crc_unit (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  // CRC-16/MODBUS, one byte per pass, reflected
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ dcf_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ rtl/core/drive_command_frame_crc16.sv @@
// Channel | Modport | Payload                                   | Role
// cmd     | sink    | left_speed, right_speed, control_flags    | one drive command
// frame   | source  | out_byte, last_byte                       | one frame byte per item
//
// Each command yields nine frame bytes, one per cycle unless frame stalls; once
// accepted, a command passes through the single CRC byte unit and sequencer.
// The CRC is folded in as frame bytes one to six enter the output register.
// rst (synchronous) returns the sequencer to idle and empties the output register.
// Stalls on frame hold the sequencer; the sequencer returns to idle and raises
// cmd.ready once the last byte is loaded into the output register.
module drive_command_frame_crc16 (
  input logic       clk,
  input logic       rst,
  dcf_cmd_if.sink   cmd,
  dcf_byte_if.source frame
);

  dcf_pkg::state_t                  state, state_next;
  logic [dcf_pkg::POS_W-1:0]        pos;
  logic [39:0]                      held;
  logic [15:0]                      crc;
  logic [15:0]                      crc_upd;
  logic [7:0]                       byte_sel;
  logic                             ov;
  logic [7:0]                       obyte;
  logic                             olast;
  logic                             accept;
  logic                             load;
  logic                             in_crc_span;

  assign accept      = cmd.valid && cmd.ready;
  assign in_crc_span = (pos >= dcf_pkg::POS_LENGTH) && (pos <= dcf_pkg::POS_FLAGS);

  always_comb begin
    unique case (pos)
      dcf_pkg::POS_HEADER:   byte_sel = dcf_pkg::FRAME_HEADER;
      dcf_pkg::POS_LENGTH:   byte_sel = dcf_pkg::FRAME_LENGTH;
      dcf_pkg::POS_LEFT_LO:  byte_sel = held[7:0];
      dcf_pkg::POS_LEFT_HI:  byte_sel = held[15:8];
      dcf_pkg::POS_RIGHT_LO: byte_sel = held[23:16];
      dcf_pkg::POS_RIGHT_HI: byte_sel = held[31:24];
      dcf_pkg::POS_FLAGS:    byte_sel = held[39:32];
      dcf_pkg::POS_CRC_LO:   byte_sel = crc[7:0];
      dcf_pkg::POS_CRC_HI:   byte_sel = crc[15:8];
      default:               byte_sel = 8'h00;
    endcase
  end

  dcf_crc_unit u_crc (
    .crc_in  (crc),
    .data    (byte_sel),
    .crc_out (crc_upd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      dcf_pkg::ST_IDLE: begin
        if (cmd.valid) state_next = dcf_pkg::ST_SEND;
      end
      dcf_pkg::ST_SEND: begin
        if (load && pos == dcf_pkg::POS_CRC_HI) state_next = dcf_pkg::ST_IDLE;
      end
      default: state_next = dcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = (state == dcf_pkg::ST_IDLE);
    load      = (state == dcf_pkg::ST_SEND) && (!ov || frame.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcf_pkg::ST_IDLE;
      pos   <= dcf_pkg::POS_HEADER;
      crc   <= dcf_pkg::CRC_INIT;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pos <= dcf_pkg::POS_HEADER;
        crc <= dcf_pkg::CRC_INIT;
      end else if (load) begin
        if (in_crc_span) crc <= crc_upd;
        if (pos == dcf_pkg::POS_CRC_HI) begin
          pos <= dcf_pkg::POS_HEADER;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      if (load) begin
        ov <= 1'b1;
      end else if (frame.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= {cmd.control_flags, cmd.right_speed, cmd.left_speed};
    end
    if (load) begin
      obyte <= byte_sel;
      olast <= (pos == dcf_pkg::POS_CRC_HI);
    end
  end

  assign frame.valid     = ov;
  assign frame.out_byte  = obyte;
  assign frame.last_byte = olast;

endmodule
